// File: rtl/cle_pkg.sv
// Shared types and constants of the canonical line editor.
package cle_pkg;

   localparam int COUNT_W = 7;
   localparam int BYTE_W  = 8;

   localparam logic [BYTE_W-1:0] CH_BS  = 8'd8;
   localparam logic [BYTE_W-1:0] CH_DEL = 8'd127;
   localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
   localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
   localparam logic [BYTE_W-1:0] CH_SP  = 8'd32;

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [1:0] RES_ECHO   = 2'd0;
   localparam logic [1:0] RES_DATA   = 2'd1;
   localparam logic [1:0] RES_STATUS = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_READY = 2'd1;
   localparam logic [1:0] STAT_REFUSED   = 2'd2;

   localparam logic REG_CANONICAL = 1'b0;
   localparam logic REG_ECHO      = 1'b1;

   typedef struct packed {
      logic [1:0]         kind;
      logic [BYTE_W-1:0]  data;
      logic [COUNT_W-1:0] count;
      logic [1:0]         status;
   } res_type;

   typedef struct packed {
      logic               wr_en;
      logic [COUNT_W-1:0] wr_addr;
      logic [BYTE_W-1:0]  wr_data;
      logic [COUNT_W-1:0] rd_addr;
   } mem_req_type;

endpackage

// File: rtl/cle_line_mem.sv
// Line buffer memory with one write port and one registered read port.
module cle_line_mem
   import cle_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [BYTE_W-1:0] rd_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic [BYTE_W-1:0] line_store_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         line_store_ff[mem_req.wr_addr[ADDR_W-1:0]] <= mem_req.wr_data;
      end
      rd_data_ff <= line_store_ff[mem_req.rd_addr[ADDR_W-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/canonical_line_editor.sv
// Top level of the canonical line editor: sequencer, line state and result register.
// A character causes 0 to 3 results, which are sent one by one from the EMIT state.
// A read fetches each delivered byte through the RD_ADDR and RD_DATA states, as set by the
// registered read port of the line buffer; status-only answers go through the EMIT state.
// One transaction is processed at a time; results leave through a single output register.
// Reset turns canonical mode and echo on and clears line count, offset and pending flag.
module canonical_line_editor
   import cle_pkg::*;
#(
   parameter int LINE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // char_byte, read_length, zero pad
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_byte, byte_count, status_code, zero pad
   output logic [1:0]  rsp_tuser,   // result_kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic        csr_data
);

   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(LINE_DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_EMIT, ST_RD_ADDR, ST_RD_DATA} state_type;

   state_type          state_ff, state_in;
   logic               canon_ff, canon_in;
   logic               echo_ff, echo_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] head_ff, head_in;
   logic               pending_ff, pending_in;
   logic [COUNT_W-1:0] take_ff, take_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   res_type            seq_ff [3];
   res_type            seq_in [3];
   logic [1:0]         seq_len_ff, seq_len_in;
   res_type            rsp_ff, rsp_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_valid_ff, rsp_valid_in;

   mem_req_type        mem_req;
   logic [BYTE_W-1:0]  rd_data;

   logic               req_acc;
   logic               slot_free;
   logic [BYTE_W-1:0]  ch;
   logic [COUNT_W-1:0] rlen;
   logic [COUNT_W-1:0] want;
   logic [COUNT_W-1:0] take;

   cle_line_mem #(
      .DEPTH (LINE_DEPTH)
   ) u_line_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign ch         = req_tdata[7:0];
   assign rlen       = req_tdata[14:8];
   assign want       = (rlen > DEPTH_C) ? DEPTH_C : rlen;
   assign take       = (want < count_ff) ? want : count_ff;

   always_comb begin
      state_in     = state_ff;
      canon_in     = canon_ff;
      echo_in      = echo_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      pending_in   = pending_ff;
      take_in      = take_ff;
      idx_in       = idx_ff;
      seq_in       = seq_ff;
      seq_len_in   = seq_len_ff;
      rsp_in       = rsp_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = count_ff;
      mem_req.wr_data = ch;
      mem_req.rd_addr = head_ff + idx_ff;

      if (csr_valid) begin
         case (csr_index)
            REG_CANONICAL: canon_in = csr_data;
            REG_ECHO:      echo_in  = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               idx_in     = '0;
               seq_len_in = 2'd0;
               if (req_tuser == REQ_READ) begin
                  if (!pending_ff) begin
                     seq_in[0]  = '{RES_STATUS, '0, '0, STAT_NOT_READY};
                     seq_len_in = 2'd1;
                  end else if (want == '0) begin
                     seq_in[0]  = '{RES_STATUS, '0, '0, STAT_OK};
                     seq_len_in = 2'd1;
                  end else begin
                     take_in  = take;
                     state_in = ST_RD_ADDR;
                  end
               end else if (!canon_ff) begin
                  seq_in[0]  = '{RES_DATA, ch, COUNT_W'(1), STAT_OK};
                  seq_in[1]  = '{RES_ECHO, ch, '0, STAT_OK};
                  seq_len_in = echo_ff ? 2'd2 : 2'd1;
               end else if (pending_ff) begin
                  seq_in[0]  = '{RES_STATUS, '0, '0, STAT_REFUSED};
                  seq_len_in = 2'd1;
               end else if (ch inside {CH_BS, CH_DEL}) begin
                  seq_in[0] = '{RES_ECHO, CH_BS, '0, STAT_OK};
                  seq_in[1] = '{RES_ECHO, CH_SP, '0, STAT_OK};
                  seq_in[2] = '{RES_ECHO, CH_BS, '0, STAT_OK};
                  if (count_ff != '0) begin
                     count_in   = count_ff - COUNT_W'(1);
                     seq_len_in = echo_ff ? 2'd3 : 2'd0;
                  end
               end else if (ch inside {CH_CR, CH_LF}) begin
                  if (count_ff < DEPTH_C) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_data = CH_LF;
                     count_in        = count_ff + COUNT_W'(1);
                  end
                  pending_in = 1'b1;
                  seq_in[0]  = '{RES_ECHO, CH_CR, '0, STAT_OK};
                  seq_in[1]  = '{RES_ECHO, CH_LF, '0, STAT_OK};
                  seq_len_in = echo_ff ? 2'd2 : 2'd0;
               end else begin
                  seq_in[0] = '{RES_ECHO, ch, '0, STAT_OK};
                  if (count_ff < DEPTH_C) begin
                     mem_req.wr_en = 1'b1;
                     count_in      = count_ff + COUNT_W'(1);
                     seq_len_in    = echo_ff ? 2'd1 : 2'd0;
                  end
               end
               if (seq_len_in != 2'd0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_in       = seq_ff[idx_ff[1:0]];
               rsp_last_in  = (idx_ff[1:0] == seq_len_ff - 2'd1);
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + COUNT_W'(1);
               if (idx_ff[1:0] == seq_len_ff - 2'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            if (slot_free) begin
               rsp_in       = '{RES_DATA, rd_data, take_ff, STAT_OK};
               rsp_last_in  = (idx_ff == take_ff - COUNT_W'(1));
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + COUNT_W'(1);
               if (idx_ff == take_ff - COUNT_W'(1)) begin
                  count_in = count_ff - take_ff;
                  if (count_ff == take_ff) begin
                     pending_in = 1'b0;
                     head_in    = '0;
                  end else begin
                     head_in = head_ff + take_ff;
                  end
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RD_ADDR;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         canon_ff     <= 1'b1;
         echo_ff      <= 1'b1;
         count_ff     <= '0;
         head_ff      <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         canon_ff     <= canon_in;
         echo_ff      <= echo_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      take_ff     <= take_in;
      idx_ff      <= idx_in;
      seq_ff      <= seq_in;
      seq_len_ff  <= seq_len_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.status, rsp_ff.count, rsp_ff.data};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("line count exceeds the buffer depth");

   a_pending_nonempty: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> count_ff != '0)
      else $error("pending line with no bytes");

   a_head_pending: assert property (@(posedge clock) disable iff (reset)
      head_ff != '0 |-> pending_ff)
      else $error("read offset set without a pending line");

   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_DATA && slot_free && idx_ff == take_ff - COUNT_W'(1))
      |=> rsp_tvalid && rsp_tlast && state_ff == ST_IDLE)
      else $error("last byte of a read not marked as last");

endmodule

// File: verif/line_editor_checker.sv
// Checker for the line editor: predicts each result from observed transactions and compares them.
module line_editor_checker
   import cle_pkg::*;
#(
   parameter int LINE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // char_byte, read_length, zero pad
   input  logic        req_tuser,   // kind
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // out_byte, byte_count, status_code, zero pad
   input  logic [1:0]  rsp_tuser,   // result_kind
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic        csr_data,
   output int          mismatches,
   output int          outstanding,
   output int          results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]         kind;
      logic [BYTE_W-1:0]  value;
      logic [COUNT_W-1:0] count;
      logic [1:0]         status;
      logic               last;
   } tty_out_type;

   tty_out_type       tty_outputs [$];
   tty_out_type       want_out;
   tty_out_type       got_out;
   logic [BYTE_W-1:0] line_buf [0:LINE_DEPTH-1];
   int                line_len;
   logic              line_ready;
   logic              canon_mode;
   logic              echo_on;
   int                error_total;
   int                seen_total;

   function automatic tty_out_type make_out(input logic [1:0] k, input logic [BYTE_W-1:0] b,
                                            input int c, input logic [1:0] s);
      tty_out_type r;
      r.kind   = k;
      r.value  = b;
      r.count  = c[COUNT_W-1:0];
      r.status = s;
      r.last   = 1'b0;
      return r;
   endfunction

   task automatic tty_process(input logic kind, input logic [BYTE_W-1:0] ch,
                              input logic [COUNT_W-1:0] len);
      tty_out_type staged [0:LINE_DEPTH];
      int          n;
      int          want;
      int          take;
      n = 0;
      if (kind == REQ_READ) begin
         want = len;
         if (!line_ready) begin
            staged[n] = make_out(RES_STATUS, '0, 0, STAT_NOT_READY);
            n++;
         end else begin
            if (want > LINE_DEPTH) want = LINE_DEPTH;
            take = (want < line_len) ? want : line_len;
            for (int i = 0; i < take; i++) begin
               staged[n] = make_out(RES_DATA, line_buf[i], take, STAT_OK);
               n++;
            end
            for (int i = 0; i + take < line_len; i++) line_buf[i] = line_buf[i + take];
            line_len = line_len - take;
            if (line_len == 0) line_ready = 1'b0;
            if (n == 0) begin
               staged[n] = make_out(RES_STATUS, '0, 0, STAT_OK);
               n++;
            end
         end
      end else if (!canon_mode) begin
         staged[n] = make_out(RES_DATA, ch, 1, STAT_OK);
         n++;
         if (echo_on) begin
            staged[n] = make_out(RES_ECHO, ch, 0, STAT_OK);
            n++;
         end
      end else if (line_ready) begin
         staged[n] = make_out(RES_STATUS, '0, 0, STAT_REFUSED);
         n++;
      end else if (ch inside {CH_BS, CH_DEL}) begin
         if (line_len > 0) begin
            line_len--;
            if (echo_on) begin
               staged[0] = make_out(RES_ECHO, CH_BS, 0, STAT_OK);
               staged[1] = make_out(RES_ECHO, CH_SP, 0, STAT_OK);
               staged[2] = make_out(RES_ECHO, CH_BS, 0, STAT_OK);
               n = 3;
            end
         end
      end else if (ch inside {CH_CR, CH_LF}) begin
         if (line_len < LINE_DEPTH) begin
            line_buf[line_len] = CH_LF;
            line_len++;
         end
         line_ready = 1'b1;
         if (echo_on) begin
            staged[0] = make_out(RES_ECHO, CH_CR, 0, STAT_OK);
            staged[1] = make_out(RES_ECHO, CH_LF, 0, STAT_OK);
            n = 2;
         end
      end else if (line_len < LINE_DEPTH) begin
         line_buf[line_len] = ch;
         line_len++;
         if (echo_on) begin
            staged[n] = make_out(RES_ECHO, ch, 0, STAT_OK);
            n++;
         end
      end
      if (n > 0) staged[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) tty_outputs.push_back(staged[i]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tty_outputs.delete();
         line_len    = 0;
         line_ready  = 1'b0;
         canon_mode  = 1'b1;
         echo_on     = 1'b1;
         error_total = 0;
         seen_total  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_CANONICAL) canon_mode = csr_data;
            else echo_on = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_out.kind   = rsp_tuser;
            got_out.value  = rsp_tdata[BYTE_W-1:0];
            got_out.count  = rsp_tdata[BYTE_W+COUNT_W-1:BYTE_W];
            got_out.status = rsp_tdata[BYTE_W+COUNT_W+1:BYTE_W+COUNT_W];
            got_out.last   = rsp_tlast;
            seen_total++;
            if (tty_outputs.size() == 0) begin
               error_total++;
               if (error_total <= 10)
                  $display("%0t: unexpected kind=%0d byte=%02h count=%0d status=%0d last=%0d",
                           $time, got_out.kind, got_out.value, got_out.count,
                           got_out.status, got_out.last);
            end else begin
               want_out = tty_outputs.pop_front();
               if (got_out.kind !== want_out.kind || got_out.value !== want_out.value ||
                   got_out.count !== want_out.count || got_out.status !== want_out.status ||
                   got_out.last !== want_out.last) begin
                  error_total++;
                  if (error_total <= 10) begin
                     $display("%0t: expected kind=%0d byte=%02h count=%0d status=%0d last=%0d",
                              $time, want_out.kind, want_out.value, want_out.count,
                              want_out.status, want_out.last);
                     $display("%0t: actual   kind=%0d byte=%02h count=%0d status=%0d last=%0d",
                              $time, got_out.kind, got_out.value, got_out.count,
                              got_out.status, got_out.last);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            tty_process(req_tuser, req_tdata[BYTE_W-1:0], req_tdata[BYTE_W+COUNT_W-1:BYTE_W]);
      end
      mismatches   <= error_total;
      outstanding  <= tty_outputs.size();
      results_seen <= seen_total;
   end

endmodule

// File: verif/canonical_line_editor_tb.sv
// Testbench top for the canonical line editor: clock, reset, stimulus, flow control and verdict.
module canonical_line_editor_tb;
   import cle_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS  = 320;
   localparam int QUIET_TAIL    = 60;
   localparam int HOLD_AT       = 150;
   localparam int HOLD_CYCLES   = 500;
   localparam int SETTLE_CYCLES = 20;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic        csr_data;

   int          mismatches;
   int          outstanding;
   int          results_seen;

   int          items_sent = 0;
   int          chars_sent = 0;
   int          reads_sent = 0;
   int          settings_applied = 0;
   bit          gaps_on = 1'b1;
   bit          stalls_on = 1'b1;
   bit          hold_done = 1'b0;
   logic        canon_set = 1'b1;

   int          random_end;
   int          seq;
   int          line_chars;
   int          extra_reads;
   logic [7:0]  c;

   canonical_line_editor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   line_editor_checker line_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .results_seen (results_seen)
   );

   always #10 clock = ~clock;

   task automatic send_item(input logic kind, input logic [7:0] ch, input logic [6:0] len);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, len, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (kind == REQ_READ) reads_sent++;
      else chars_sent++;
   endtask

   task automatic send_char(input logic [7:0] ch);
      send_item(REQ_CHAR, ch, 7'($urandom_range(0, 127)));
   endtask

   task automatic send_read(input logic [6:0] len);
      send_item(REQ_READ, 8'($urandom_range(0, 255)), len);
   endtask

   function automatic logic [6:0] read_len_draw();
      int         pick;
      logic [6:0] len;
      pick = $urandom_range(0, 9);
      if (pick == 0) len = 7'd0;
      else if (pick == 1) len = 7'($urandom_range(64, 127));
      else len = 7'($urandom_range(1, 20));
      return len;
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle_and_write(input logic canon, input logic echo);
      drain();
      write_reg(REG_CANONICAL, canon);
      write_reg(REG_ECHO, echo);
      canon_set = canon;
      settings_applied++;
   endtask

   initial begin
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (!hold_done && items_sent >= HOLD_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      #50_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_CHAR;
      csr_valid  = 1'b0;
      csr_index  = REG_CANONICAL;
      csr_data   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      settle_and_write(1'b1, 1'b1);
      send_read(7'd5);
      send_char(CH_BS);
      send_char(8'h61);
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CH_DEL);
      send_char(CH_BS);
      send_char(CH_CR);
      send_char(8'h62);
      send_read(7'd0);
      send_read(7'd1);
      send_read(7'd127);

      settle_and_write(1'b1, 1'b0);
      send_char(8'h78);
      send_char(CH_DEL);
      send_char(CH_BS);
      send_char(8'h79);
      send_char(CH_LF);
      send_read(7'd64);

      settle_and_write(1'b1, 1'b1);
      send_char(8'h70);
      send_char(8'h71);
      settle_and_write(1'b0, 1'b1);
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CH_CR);
      send_read(7'd3);
      settle_and_write(1'b0, 1'b0);
      send_char(CH_DEL);
      settle_and_write(1'b1, 1'b1);
      send_char(CH_BS);
      send_char(CH_LF);
      send_read(7'd64);

      random_end = items_sent + RANDOM_ITEMS;
      seq = 0;
      while (items_sent < random_end) begin
         if (items_sent >= random_end - QUIET_TAIL) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         if (gaps_on && seq % 5 == 4)
            settle_and_write($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
         if (canon_set) begin
            line_chars = (seq % 6 == 0) ? $urandom_range(66, 80) : $urandom_range(0, 12);
            for (int i = 0; i < line_chars; i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_char($urandom_range(0, 1) ? CH_BS : CH_DEL);
               end else begin
                  c = 8'($urandom_range(0, 255));
                  if (c inside {CH_CR, CH_LF}) c = c ^ 8'h20;
                  send_char(c);
               end
            end
            if ($urandom_range(0, 7) == 0) send_read(read_len_draw());
            send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
            if ($urandom_range(0, 3) == 0) send_char(8'($urandom_range(0, 255)));
            extra_reads = $urandom_range(0, 3);
            repeat (extra_reads) send_read(read_len_draw());
            send_read(7'($urandom_range(64, 127)));
            if ($urandom_range(0, 5) == 0) send_read(read_len_draw());
         end else begin
            repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0) send_read(read_len_draw());
         end
         seq++;
      end

      drain();
      $display("Run covered %0d transactions (%0d characters, %0d reads) under %0d settings.",
               items_sent, chars_sent, reads_sent, settings_applied);
      $display("Checked %0d results with one long output hold; %0d mismatches.",
               results_seen, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
